### rtl/pccu_pkg.sv
`default_nettype none
package pccu_pkg;

  // Fixed formats of the coordinate and lattice fields
  localparam int COORD_FRAC      = 16;
  localparam int LAT_FRAC        = 10;
  localparam int LAT_HALF        = 1 << (LAT_FRAC - 1);
  localparam int REG_WIDTH       = 63;
  localparam int CFG_INDEX_WIDTH = 2;

  // Cycles from a register write until the derived cell terms are valid
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_LATTICE_ONE   = 2'd0,
    CFG_LATTICE_TWO   = 2'd1,
    CFG_LATTICE_THREE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FUNC_TO_FRAC   = 2'd0,
    FUNC_TO_CART   = 2'd1,
    FUNC_WRAP      = 2'd2,
    FUNC_MIN_IMAGE = 2'd3
  } func_t;

  // Per-item control that travels beside the datapath
  typedef struct packed {
    logic  valid;
    func_t func;
    logic  degen;
  } ctl_t;

  // Status of the cell registers toward the datapath
  typedef struct packed {
    logic busy;
    logic degen;
    logic vol_neg;
  } cell_status_t;

  // Width of the signed numerator (c . r) * 2^11 + |V|
  function automatic int num_width(int cw, int l);
    int dw;
    int vw;
    int a;
    dw = (2 * l + 1) + (cw + 1) + 2;
    vw = 3 * l + 1;
    a  = (dw + LAT_FRAC + 1 > vw) ? dw + LAT_FRAC + 1 : vw;
    return a + 1;
  endfunction

  // Register stages of one fractional lane
  function automatic int frac_latency(int cw, int l);
    return num_width(cw, l) + 7;
  endfunction

endpackage
`default_nettype wire

### rtl/pccu_in_if.sv
`default_nettype none
interface pccu_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] other_x;
  logic signed [COORD_WIDTH-1:0] other_y;
  logic signed [COORD_WIDTH-1:0] other_z;

  modport source (output valid, func, point_x, point_y, point_z, other_x, other_y, other_z,
                  input ready);
  modport sink (input valid, func, point_x, point_y, point_z, other_x, other_y, other_z,
                output ready);
endinterface
`default_nettype wire

### rtl/pccu_out_if.sv
`default_nettype none
interface pccu_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          degenerate;

  modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
  modport sink (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface
`default_nettype wire

### rtl/periodic_cell_coordinate_unit_core.sv
// Triclinic cell coordinate unit: converts Cartesian to fractional, fractional to
// Cartesian, wraps a point into the cell and forms minimum-image displacements,
// all in signed Q16.16 with saturation. Three fractional lanes each run a dot
// product and a radix-2 restoring divider; three Cartesian lanes rebuild the
// result. One item is taken every cycle while the output buffer has room and the
// cell terms are settled; the divider yields one quotient bit per stage.
// After reset and after every configuration write the input stays not ready
// while the cofactors and volume refill. A two-entry output buffer
// lets items keep entering while a result waits to be taken.
`default_nettype none
module periodic_cell_coordinate_unit_core #(
  parameter int COORD_WIDTH         = 32,
  parameter int LATTICE_FIELD_WIDTH = 21
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire [pccu_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire [pccu_pkg::REG_WIDTH-1:0]        cfg_data,
  pccu_in_if.sink                              in_item,
  pccu_out_if.source                           out_item
);
  import pccu_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int L   = LATTICE_FIELD_WIDTH;
  localparam int FL  = frac_latency(CW, L);
  localparam int TOT = FL + 5;

  logic signed [L-1:0]   lat_vec [3][3];
  logic signed [2*L:0]   crs [3][3];
  logic [3*L:0]          vabs;
  cell_status_t          status;

  logic                  en;
  logic                  acc;
  ctl_t                  ctl_q [TOT];
  logic signed [CW:0]    r_s0 [3];
  logic signed [CW-1:0]  p_s0 [3];
  logic signed [CW-1:0]  pin [3];
  logic signed [CW-1:0]  qin [3];
  logic signed [CW-1:0]  f_sat [3];
  logic [COORD_FRAC-1:0] f_frac [3];
  logic signed [CW-1:0]  pass_out [3];
  logic signed [CW:0]    fs [3];
  logic signed [CW-1:0]  sat_q [4][3];
  logic signed [L-1:0]   cols [3][3];
  logic signed [CW-1:0]  cart [3];
  logic signed [CW-1:0]  res [3];
  logic signed [CW-1:0]  obuf [2][3];
  logic                  odeg [2];
  logic [1:0]            cnt;
  logic                  push;
  logic                  pop;
  logic                  wr;
  ctl_t                  last;

  pccu_cell #(.LATTICE_FIELD_WIDTH(L)) u_cell (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .lat_vec  (lat_vec),
    .crs      (crs),
    .vabs     (vabs),
    .status   (status)
  );

  // Whole pipeline moves while the output buffer has a free slot
  assign en            = (cnt != 2'd2);
  assign in_item.ready = en && !status.busy;
  assign acc           = in_item.valid && in_item.ready;

  assign pin[0] = in_item.point_x;
  assign pin[1] = in_item.point_y;
  assign pin[2] = in_item.point_z;
  assign qin[0] = in_item.other_x;
  assign qin[1] = in_item.other_y;
  assign qin[2] = in_item.other_z;

  // Control shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < TOT; d++) begin
        ctl_q[d] <= '0;
      end
    end else if (en) begin
      ctl_q[0].valid <= acc;
      ctl_q[0].func  <= func_t'(in_item.func);
      ctl_q[0].degen <= status.degen;
      for (int d = 1; d < TOT; d++) begin
        ctl_q[d] <= ctl_q[d-1];
      end
    end
  end

  // Input stage: displacement for minimum image
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (func_t'(in_item.func) == FUNC_MIN_IMAGE) begin
          r_s0[k] <= (CW+1)'(qin[k]) - (CW+1)'(pin[k]);
        end else begin
          r_s0[k] <= (CW+1)'(pin[k]);
        end
        p_s0[k] <= pin[k];
      end
    end
  end

  // Fractional lanes, one per axis
  for (genvar i = 0; i < 3; i++) begin : g_frac
    pccu_frac_lane #(.COORD_WIDTH(CW), .LATTICE_FIELD_WIDTH(L)) u_frac (
      .clk     (clk),
      .en      (en),
      .r       (r_s0),
      .crs_row (crs[i]),
      .vol_neg (status.vol_neg),
      .vabs    (vabs),
      .pass_in (p_s0[i]),
      .f_sat   (f_sat[i]),
      .f_frac  (f_frac[i]),
      .pass_out(pass_out[i])
    );
  end

  // Merge: pick the fractional vector for the Cartesian lanes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        case (ctl_q[FL].func)
          FUNC_TO_CART: fs[i] <= (CW+1)'(pass_out[i]);
          FUNC_WRAP:    fs[i] <= $signed({{(CW+1-COORD_FRAC){1'b0}}, f_frac[i]});
          default:      fs[i] <= (CW+1)'($signed(f_frac[i]));
        endcase
        sat_q[0][i] <= f_sat[i];
        for (int d = 1; d < 4; d++) begin
          sat_q[d][i] <= sat_q[d-1][i];
        end
      end
    end
  end

  // Cartesian lanes, one per output component
  for (genvar j = 0; j < 3; j++) begin : g_cart
    for (genvar i = 0; i < 3; i++) begin : g_col
      assign cols[j][i] = lat_vec[i][j];
    end
    pccu_cart_lane #(.COORD_WIDTH(CW), .LATTICE_FIELD_WIDTH(L)) u_cart (
      .clk(clk),
      .en (en),
      .fs (fs),
      .col(cols[j]),
      .r  (cart[j])
    );
  end

  // Result select
  assign last = ctl_q[TOT-1];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (last.func == FUNC_TO_CART) begin
        res[j] = cart[j];
      end else if (last.degen) begin
        res[j] = '0;
      end else if (last.func == FUNC_TO_FRAC) begin
        res[j] = sat_q[3][j];
      end else begin
        res[j] = cart[j];
      end
    end
  end

  // Two-entry output buffer
  assign push = en && last.valid;
  assign pop  = out_item.valid && out_item.ready;
  assign wr   = (cnt == 2'd1) && !pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // Head slot takes a new result when it would otherwise be empty
  always_ff @(posedge clk) begin
    if (push && !wr) begin
      obuf[0] <= res;
      odeg[0] <= last.degen;
    end else if (pop) begin
      obuf[0] <= obuf[1];
      odeg[0] <= odeg[1];
    end
    if (push && wr) begin
      obuf[1] <= res;
      odeg[1] <= last.degen;
    end
  end

  assign out_item.valid      = (cnt != 2'd0);
  assign out_item.out_x      = obuf[0][0];
  assign out_item.out_y      = obuf[0][1];
  assign out_item.out_z      = obuf[0][2];
  assign out_item.degenerate = odeg[0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");

  a_cfg_holdoff: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !in_item.ready)
    else $error("item accepted while cell terms refill");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_item.valid && in_item.ready) |=> ctl_q[0].valid)
    else $error("accepted item lost at input stage");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt != 2'd2))
    else $error("result pushed into full output buffer");

endmodule
`default_nettype wire

### rtl/pccu_cell.sv
`default_nettype none
module pccu_cell #(
  parameter int LATTICE_FIELD_WIDTH = 21
) (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       cfg_write,
  input  wire  [pccu_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  wire  [pccu_pkg::REG_WIDTH-1:0]            cfg_data,
  output logic signed [LATTICE_FIELD_WIDTH-1:0]     lat_vec [3][3],
  output logic signed [2*LATTICE_FIELD_WIDTH:0]     crs [3][3],
  output logic [3*LATTICE_FIELD_WIDTH:0]            vabs,
  output pccu_pkg::cell_status_t                    status
);
  import pccu_pkg::*;

  localparam int L   = LATTICE_FIELD_WIDTH;
  localparam int CRW = 2 * L + 1;
  localparam int VW  = 3 * L + 1;

  logic [REG_WIDTH-1:0]  lv [3];
  logic signed [VW-1:0]  vprod [3];
  logic signed [VW-1:0]  vol;
  logic [2:0]            settle;
  logic                  vol_neg;
  logic                  degen;

  // Lattice registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lv[0] <= '0;
      lv[1] <= '0;
      lv[2] <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LATTICE_ONE:   lv[0] <= cfg_data;
        CFG_LATTICE_TWO:   lv[1] <= cfg_data;
        CFG_LATTICE_THREE: lv[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack x, y, z fields
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lat_vec[i][j] = $signed(lv[i][j*L +: L]);
      end
    end
  end

  // Cofactor rows c_i = a_(i+1) x a_(i+2)
  for (genvar i = 0; i < 3; i++) begin : g_crs
    localparam int U = (i + 1) % 3;
    localparam int V = (i + 2) % 3;
    always_ff @(posedge clk) begin
      crs[i][0] <= CRW'(lat_vec[U][1] * lat_vec[V][2]) - CRW'(lat_vec[U][2] * lat_vec[V][1]);
      crs[i][1] <= CRW'(lat_vec[U][2] * lat_vec[V][0]) - CRW'(lat_vec[U][0] * lat_vec[V][2]);
      crs[i][2] <= CRW'(lat_vec[U][0] * lat_vec[V][1]) - CRW'(lat_vec[U][1] * lat_vec[V][0]);
    end
  end

  // Volume a1 . c1, then its magnitude and sign
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      vprod[j] <= VW'(lat_vec[0][j] * crs[0][j]);
    end
    vol     <= vprod[0] + vprod[1] + vprod[2];
    vabs    <= vol[VW-1] ? VW'(-vol) : VW'(vol);
    vol_neg <= vol[VW-1];
    degen   <= (vol == '0);
  end

  // Hold off items while the derived terms refill
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != 3'd0) begin
      settle <= settle - 3'd1;
    end
  end

  assign status.busy    = (settle != 3'd0);
  assign status.degen   = degen;
  assign status.vol_neg = vol_neg;

endmodule
`default_nettype wire

### rtl/pccu_frac_lane.sv
`default_nettype none
module pccu_frac_lane #(
  parameter int COORD_WIDTH         = 32,
  parameter int LATTICE_FIELD_WIDTH = 21
) (
  input  wire                                   clk,
  input  wire                                   en,
  input  wire signed [COORD_WIDTH:0]            r [3],
  input  wire signed [2*LATTICE_FIELD_WIDTH:0]  crs_row [3],
  input  wire                                   vol_neg,
  input  wire [3*LATTICE_FIELD_WIDTH:0]         vabs,
  input  wire signed [COORD_WIDTH-1:0]          pass_in,
  output logic signed [COORD_WIDTH-1:0]         f_sat,
  output logic [pccu_pkg::COORD_FRAC-1:0]       f_frac,
  output logic signed [COORD_WIDTH-1:0]         pass_out
);
  import pccu_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int L   = LATTICE_FIELD_WIDTH;
  localparam int RW  = CW + 1;
  localparam int CRW = 2 * L + 1;
  localparam int LOW = L;
  localparam int HIW = CRW - LOW;
  localparam int DW  = CRW + RW + 2;
  localparam int NW  = num_width(CW, L);
  localparam int AW  = NW;
  localparam int VW  = 3 * L + 1;
  localparam int DVW = VW + 1;
  localparam int FL  = frac_latency(CW, L);

  logic signed [LOW+RW:0]   plo [3];
  logic signed [HIW+RW-1:0] phi [3];
  logic signed [DW-1:0]     prod [3];
  logic signed [DW-1:0]     dot;
  logic signed [DW-1:0]     sdot;
  logic signed [NW-1:0]     n;
  logic [DVW-1:0]           dvs;
  logic [DVW-1:0]           rem_q [AW+1];
  logic [AW-1:0]            nq_q [AW+1];
  logic                     neg_q [AW+1];
  logic signed [AW:0]       qv;
  logic signed [CW-1:0]     pass_q [FL];

  assign dvs = {vabs, 1'b0};

  // Partial products, cofactor split in low and high halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        plo[k] <= $signed({1'b0, crs_row[k][LOW-1:0]}) * r[k];
        phi[k] <= $signed(crs_row[k][CRW-1:LOW]) * r[k];
      end
    end
  end

  // Dot product, sign fold, numerator and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= (DW'(phi[k]) <<< LOW) + DW'(plo[k]);
      end
      dot      <= prod[0] + prod[1] + prod[2];
      sdot     <= vol_neg ? -dot : dot;
      n        <= (NW'(sdot) <<< (LAT_FRAC + 1)) + NW'($signed({1'b0, vabs}));
      rem_q[0] <= '0;
      nq_q[0]  <= n[NW-1] ? AW'(-n) : AW'(n);
      neg_q[0] <= n[NW-1];
    end
  end

  // Restoring divider, one quotient bit per stage
  for (genvar s = 0; s < AW; s++) begin : g_div
    logic [DVW:0] t;
    logic         ge;
    assign t  = {rem_q[s], nq_q[s][AW-1]};
    assign ge = (t >= {1'b0, dvs});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1] <= ge ? DVW'(t - {1'b0, dvs}) : t[DVW-1:0];
        nq_q[s+1]  <= {nq_q[s][AW-2:0], ge};
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  // Floor correction for negative numerators
  always_comb begin
    if (neg_q[AW]) begin
      qv = (rem_q[AW] != '0) ? ~$signed({1'b0, nq_q[AW]}) : -$signed({1'b0, nq_q[AW]});
    end else begin
      qv = $signed({1'b0, nq_q[AW]});
    end
  end

  // Saturated value and the fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      f_frac <= qv[COORD_FRAC-1:0];
      if ((&qv[AW:CW-1]) || !(|qv[AW:CW-1])) begin
        f_sat <= qv[CW-1:0];
      end else begin
        f_sat <= qv[AW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  // Side value delayed to match the lane
  always_ff @(posedge clk) begin
    if (en) begin
      pass_q[0] <= pass_in;
      for (int d = 1; d < FL; d++) begin
        pass_q[d] <= pass_q[d-1];
      end
    end
  end
  assign pass_out = pass_q[FL-1];

endmodule
`default_nettype wire

### rtl/pccu_cart_lane.sv
`default_nettype none
module pccu_cart_lane #(
  parameter int COORD_WIDTH         = 32,
  parameter int LATTICE_FIELD_WIDTH = 21
) (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire signed [COORD_WIDTH:0]           fs [3],
  input  wire signed [LATTICE_FIELD_WIDTH-1:0] col [3],
  output logic signed [COORD_WIDTH-1:0]        r
);
  import pccu_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int L  = LATTICE_FIELD_WIDTH;
  localparam int FW = CW + 1;
  localparam int PW = FW + L;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] pr [3];
  logic signed [SW-1:0] s;

  // f_i * a_i component, rounded sum, scale and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr[i] <= fs[i] * col[i];
      end
      s <= SW'(pr[0]) + SW'(pr[1]) + SW'(pr[2]) + $signed(SW'(LAT_HALF));
      if ((&s[SW-1:LAT_FRAC+CW-1]) || !(|s[SW-1:LAT_FRAC+CW-1])) begin
        r <= s[LAT_FRAC +: CW];
      end else begin
        r <= s[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

endmodule
`default_nettype wire

### dv/testbench.sv
`default_nettype none
module testbench;
  import pccu_pkg::*;

  localparam int CW = 32;
  localparam int LW = 21;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT = 150;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef logic signed [127:0] wide_t;
  localparam wide_t SAT_HI = 128'sd2147483647;
  localparam wide_t SAT_LO = -SAT_HI - 1;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 degen;
  } coord_result_t;

  // Directed row: lattice_sel selects the lattice, known marks a typed-in result
  typedef struct {
    int                   lattice_sel;
    func_t                func;
    logic signed [CW-1:0] p[3];
    logic signed [CW-1:0] q[3];
    bit                   known;
    coord_result_t        res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [REG_WIDTH-1:0]       cfg_data  = '0;

  pccu_in_if  #(.COORD_WIDTH(CW)) in_bus ();
  pccu_out_if #(.COORD_WIDTH(CW)) out_bus ();

  periodic_cell_coordinate_unit_core #(
    .COORD_WIDTH        (CW),
    .LATTICE_FIELD_WIDTH(LW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_item  (in_bus),
    .out_item (out_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow lattice registers and expected results in flight
  logic [REG_WIDTH-1:0] lattice_reg[3];
  coord_result_t        pending_results[$];
  int                   mismatches = 0;
  int                   cycles = 0;
  bit                   idling = 1'b1;
  int                   hold_off = 0;
  int                   sink_stall = 0;

  // Cell geometry derived from the lattice registers
  wide_t cell_vec[3][3];
  wide_t cofactor[3][3];
  wide_t cell_volume;

  function automatic void derive_cell();
    logic signed [LW-1:0] fld;
    logic signed [63:0]   v64;
    wide_t                acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        fld = lattice_reg[i][j*LW +: LW];
        cell_vec[i][j] = fld;
      end
    end
    for (int i = 0; i < 3; i++) begin
      cofactor[i][0] = cell_vec[(i+1)%3][1] * cell_vec[(i+2)%3][2]
                     - cell_vec[(i+1)%3][2] * cell_vec[(i+2)%3][1];
      cofactor[i][1] = cell_vec[(i+1)%3][2] * cell_vec[(i+2)%3][0]
                     - cell_vec[(i+1)%3][0] * cell_vec[(i+2)%3][2];
      cofactor[i][2] = cell_vec[(i+1)%3][0] * cell_vec[(i+2)%3][1]
                     - cell_vec[(i+1)%3][1] * cell_vec[(i+2)%3][0];
    end
    acc = 0;
    for (int j = 0; j < 3; j++) acc = acc + cell_vec[0][j] * cofactor[0][j];
    // volume register is 64 bits wide and wraps
    v64 = acc[63:0];
    cell_volume = v64;
  endfunction

  function automatic logic signed [CW-1:0] saturate(wide_t v);
    if (v > SAT_HI) return SAT_HI[CW-1:0];
    if (v < SAT_LO) return SAT_LO[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Cramer's rule, rounded to nearest with ties upward, Q.16
  function automatic void cart_to_frac(input wide_t r[3], output wide_t f[3]);
    wide_t vabs, num, den, quo;
    vabs = (cell_volume < 0) ? -cell_volume : cell_volume;
    den = vabs <<< 1;
    for (int i = 0; i < 3; i++) begin
      num = 0;
      for (int k = 0; k < 3; k++) num = num + cofactor[i][k] * r[k];
      if (cell_volume < 0) num = -num;
      num = (num <<< (LAT_FRAC + 1)) + vabs;
      quo = num / den;
      if (num < 0 && quo * den != num) quo = quo - 1;
      f[i] = quo;
    end
  endfunction

  function automatic void frac_to_cart(input wide_t f[3], output logic signed [CW-1:0] r[3]);
    wide_t s;
    for (int j = 0; j < 3; j++) begin
      s = LAT_HALF;
      for (int i = 0; i < 3; i++) s = s + f[i] * cell_vec[i][j];
      r[j] = saturate(s >>> LAT_FRAC);
    end
  endfunction

  function automatic coord_result_t predict_coord(func_t fn, logic signed [CW-1:0] p[3],
                                                  logic signed [CW-1:0] q[3]);
    coord_result_t        res;
    wide_t                pt[3], fr[3];
    logic signed [CW-1:0] r[3];
    derive_cell();
    res.degen = (cell_volume == 0);
    r = '{default: '0};
    for (int i = 0; i < 3; i++) pt[i] = p[i];
    if (fn == FUNC_TO_CART) begin
      frac_to_cart(pt, r);
    end else if (!res.degen) begin
      if (fn == FUNC_MIN_IMAGE) begin
        for (int i = 0; i < 3; i++) pt[i] = wide_t'(q[i]) - wide_t'(p[i]);
      end
      cart_to_frac(pt, fr);
      if (fn == FUNC_TO_FRAC) begin
        for (int i = 0; i < 3; i++) r[i] = saturate(fr[i]);
      end else begin
        // keep the fraction bits; minimum image recenters to [-0.5, 0.5)
        for (int i = 0; i < 3; i++) begin
          pt[i] = {112'd0, fr[i][COORD_FRAC-1:0]};
          if (fn == FUNC_MIN_IMAGE && fr[i][COORD_FRAC-1]) pt[i] = pt[i] - (1 <<< COORD_FRAC);
        end
        frac_to_cart(pt, r);
      end
    end
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    return res;
  endfunction

  function automatic logic [REG_WIDTH-1:0] pack_vec(logic [LW-1:0] x, logic [LW-1:0] y,
                                                     logic [LW-1:0] z);
    return {z, y, x};
  endfunction

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk) begin
    coord_result_t exp_res;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %0d %0d %0d deg %0b",
                                       out_bus.out_x, out_bus.out_y, out_bus.out_z,
                                       out_bus.degenerate);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_bus.out_x !== exp_res.x || out_bus.out_y !== exp_res.y ||
            out_bus.out_z !== exp_res.z || out_bus.degenerate !== exp_res.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                     exp_res.x, exp_res.y, exp_res.z, exp_res.degen,
                     out_bus.out_x, out_bus.out_y, out_bus.out_z, out_bus.degenerate);
        end
      end
    end
  end

  // Output ready: random stall bursts, plus a long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_bus.ready = 1'b0;
        hold_off--;
      end else if (!idling) begin
        out_bus.ready = 1'b1;
      end else if (sink_stall > 0) begin
        out_bus.ready = 1'b0;
        sink_stall--;
      end else begin
        out_bus.ready = 1'b1;
        if ($urandom_range(0, 6) == 0) sink_stall = $urandom_range(1, 11);
      end
    end
  end

  // Offer one item; returns at the accepting edge
  task automatic send_item(func_t fn, logic signed [CW-1:0] p[3], logic signed [CW-1:0] q[3],
                           bit known, coord_result_t known_res);
    coord_result_t exp_res;
    @(negedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_bus.valid   = 1'b1;
    in_bus.func    = fn;
    in_bus.point_x = p[0];
    in_bus.point_y = p[1];
    in_bus.point_z = p[2];
    in_bus.other_x = q[0];
    in_bus.other_y = q[1];
    in_bus.other_z = q[2];
    do @(posedge clk); while (!in_bus.ready);
    exp_res = known ? known_res : predict_coord(fn, p, q);
    pending_results.push_back(exp_res);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_lattice(logic [CFG_INDEX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == CFG_LATTICE_ONE || idx == CFG_LATTICE_TWO || idx == CFG_LATTICE_THREE)
      lattice_reg[idx] = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic load_cell(logic [REG_WIDTH-1:0] a1, logic [REG_WIDTH-1:0] a2,
                           logic [REG_WIDTH-1:0] a3);
    wait_drained();
    write_lattice(CFG_LATTICE_ONE, a1);
    write_lattice(CFG_LATTICE_TWO, a2);
    write_lattice(CFG_LATTICE_THREE, a3);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0:       return $urandom();
      1:       return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic [LW-1:0] rand_field();
    return LW'($urandom_range(0, (1 << LW) - 1));
  endfunction

  localparam logic [LW-1:0] ONE_Q10 = 21'd1024;
  localparam logic [LW-1:0] FIELD_MAX = 21'h0F_FFFF;
  localparam logic [LW-1:0] FIELD_MIN = 21'h10_0000;
  localparam logic signed [CW-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;

  directed_row_t rows[$];

  task automatic add_row(int lattice_sel, func_t fn, logic signed [CW-1:0] px,
                         logic signed [CW-1:0] py,
                         logic signed [CW-1:0] pz, logic signed [CW-1:0] qx,
                         logic signed [CW-1:0] qy, logic signed [CW-1:0] qz, int known,
                         logic signed [CW-1:0] ex, logic signed [CW-1:0] ey,
                         logic signed [CW-1:0] ez, int edeg);
    directed_row_t r;
    r.lattice_sel = lattice_sel;
    r.func = fn;
    r.p = '{px, py, pz};
    r.q = '{qx, qy, qz};
    r.known = (known != 0);
    r.res.x = ex;
    r.res.y = ey;
    r.res.z = ez;
    r.res.degen = (edeg != 0);
    rows.push_back(r);
  endtask

  initial begin
    logic signed [CW-1:0] p[3], q[3];
    coord_result_t        none;
    int                   cur_cell;
    int                   mode;
    func_t                fn;
    in_bus.valid = 1'b0;
    in_bus.func = FUNC_TO_FRAC;
    {in_bus.point_x, in_bus.point_y, in_bus.point_z} = '0;
    {in_bus.other_x, in_bus.other_y, in_bus.other_z} = '0;
    lattice_reg = '{default: '0};
    none = '{x: '0, y: '0, z: '0, degen: 1'b0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero lattice after reset: every func flags a degenerate cell
    add_row(0, FUNC_TO_FRAC, CMAX, CMIN, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(0, FUNC_TO_CART, CMAX, CMIN, CMAX, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(0, FUNC_WRAP, CMIN, CMAX, -1, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(0, FUNC_MIN_IMAGE, CMIN, CMAX, 1, CMAX, CMIN, -1, 1, 0, 0, 0, 1);
    // Unit cube: conversions are identities, wrap and minimum image are easy
    add_row(1, FUNC_TO_FRAC, 32'sh1_0000, -32'sh1_0000, CMAX, 5, 5, 5, 1,
            32'sh1_0000, -32'sh1_0000, CMAX, 0);
    add_row(1, FUNC_TO_FRAC, CMIN, 0, -1, 0, 0, 0, 1, CMIN, 0, -1, 0);
    add_row(1, FUNC_TO_CART, CMAX, CMIN, 32'sh8000, 0, 0, 0, 1, CMAX, CMIN, 32'sh8000, 0);
    add_row(1, FUNC_WRAP, 32'sh1_8000, -32'sh8000, CMAX, 0, 0, 0, 1,
            32'sh8000, 32'sh8000, 32'shFFFF, 0);
    add_row(1, FUNC_WRAP, CMIN, -1, 0, 0, 0, 0, 1, 0, 32'shFFFF, 0, 0);
    add_row(1, FUNC_MIN_IMAGE, 0, 0, 0, 32'sh8000, -32'sh8000, CMAX, 1,
            -32'sh8000, -32'sh8000, -1, 0);
    add_row(1, FUNC_MIN_IMAGE, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, 0, 0, 0, 0, 0);
    // Skewed cell, results from the predictor
    add_row(2, FUNC_TO_FRAC, 32'sh0005_0000, 32'sh0003_8000, -32'sh0002_0000, 0, 0, 0,
            0, 0, 0, 0, 0);
    add_row(2, FUNC_TO_FRAC, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(2, FUNC_TO_CART, CMAX, CMIN, CMAX, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(2, FUNC_TO_CART, 32'sh0000_8000, 32'sh0001_0000, -32'sh0000_4000, 0, 0, 0,
            0, 0, 0, 0, 0);
    add_row(2, FUNC_WRAP, CMIN, CMAX, 32'sh0030_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(2, FUNC_MIN_IMAGE, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0);
    add_row(2, FUNC_MIN_IMAGE, 32'sh0001_0000, 0, 0, 32'sh000A_0000, 32'sh0008_0000,
            32'sh000C_0000, 0, 0, 0, 0, 0);
    // Degenerate but nonzero cell: frac to cart still converts
    add_row(3, FUNC_TO_CART, 32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000, 0, 0, 0,
            0, 0, 0, 0, 0);
    add_row(3, FUNC_TO_FRAC, CMAX, 1, 1, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(3, FUNC_MIN_IMAGE, 1, 2, 3, 4, 5, 6, 1, 0, 0, 0, 1);

    cur_cell = 0;
    foreach (rows[i]) begin
      if (rows[i].lattice_sel != cur_cell) begin
        cur_cell = rows[i].lattice_sel;
        case (cur_cell)
          1: load_cell(pack_vec(ONE_Q10, '0, '0), pack_vec('0, ONE_Q10, '0),
                       pack_vec('0, '0, ONE_Q10));
          2: load_cell(pack_vec(21'd10240, '0, '0), pack_vec(21'd2560, 21'd8192, '0),
                       pack_vec(-21'sd1536, 21'd3072, 21'd12288));
          default: load_cell(pack_vec(21'd2048, 21'd1024, '0),
                             pack_vec('0, 21'd3072, 21'd512),
                             pack_vec(21'd2048, 21'd1024, '0));
        endcase
      end
      send_item(rows[i].func, rows[i].p, rows[i].q, rows[i].known, rows[i].res);
    end

    // Random phases over several cells
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_cell(pack_vec(21'd8192 + rand_field() % 21'd4096, rand_field() % 21'd2048, '0),
                     pack_vec(rand_field() % 21'd4096, 21'd9000 + rand_field() % 21'd4096,
                              '0),
                     pack_vec(rand_field() % 21'd2048, rand_field() % 21'd2048,
                              21'd7000 + rand_field() % 21'd8192));
        1: begin
          load_cell(REG_WIDTH'({$urandom(), $urandom()}), REG_WIDTH'({$urandom(), $urandom()}),
                    REG_WIDTH'({$urandom(), $urandom()}));
          write_lattice(CFG_UNUSED_INDEX, REG_WIDTH'({$urandom(), $urandom()}));
        end
        2: load_cell(pack_vec(FIELD_MAX, '0, '0), pack_vec('0, FIELD_MAX, '0),
                     pack_vec('0, '0, FIELD_MAX));
        3: load_cell(pack_vec(FIELD_MIN, '0, '0), pack_vec('0, FIELD_MIN, '0),
                     pack_vec(FIELD_MIN, FIELD_MIN, FIELD_MIN));
        4: load_cell(pack_vec(FIELD_MAX, FIELD_MAX, FIELD_MAX),
                     pack_vec(FIELD_MIN, FIELD_MIN, FIELD_MIN),
                     pack_vec(FIELD_MAX, FIELD_MIN, FIELD_MAX));
        default: begin
          load_cell(pack_vec(rand_field(), rand_field(), rand_field()),
                    pack_vec(rand_field(), rand_field(), rand_field()),
                    pack_vec(rand_field(), rand_field(), rand_field()));
          idling = 1'b0;
        end
      endcase
      // Long output hold-off so the pipeline backs up into the input
      if (ph == 1) hold_off = 400;
      for (int n = 0; n < 90; n++) begin
        fn = func_t'($urandom_range(0, 3));
        mode = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
          p[k] = rand_coord(mode);
          q[k] = rand_coord(mode);
        end
        send_item(fn, p, q, 1'b0, none);
      end
    end

    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/pccu_pkg.sv
rtl/pccu_in_if.sv
rtl/pccu_out_if.sv
rtl/pccu_cell.sv
rtl/pccu_frac_lane.sv
rtl/pccu_cart_lane.sv
rtl/periodic_cell_coordinate_unit_core.sv
dv/testbench.sv
